@@ rtl/bdsl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsl_pkg
// Shared types and constants for the debounced short/long press button unit.
// ----------------------------------------------------------------------------
package bdsl_pkg;

  // timer and register widths
  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_BITS      = 32;
  localparam int CFG_BITS      = 16;
  localparam int CFG_IDX_BITS  = 2;

  // register reset values
  localparam logic [CFG_BITS-1:0] BOOT_IGNORE_RST = 16'd100;
  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST    = 16'd30;
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RST  = 16'd1500;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLED     = 2'd0,
    REG_BOOT_IGNORE = 2'd1,
    REG_DEBOUNCE    = 2'd2,
    REG_LONG_PRESS  = 2'd3
  } reg_idx_t;

  // event kinds
  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  // configuration register set
  typedef struct packed {
    logic                enabled;
    logic [CFG_BITS-1:0] boot_ignore_ms;
    logic [CFG_BITS-1:0] debounce_ms;
    logic [CFG_BITS-1:0] long_press_ms;
  } cfg_t;

  // one evaluated result
  typedef struct packed {
    logic valid;
    logic kind;
  } evt_t;

endpackage

@@ rtl/bdsl_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsl_eval
// Debounce and press classification state with its single-pass update.
// ----------------------------------------------------------------------------
module bdsl_eval #(
  parameter int TIME_BITS = bdsl_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 pin_level,
  input  bdsl_pkg::cfg_t       cfg,
  output bdsl_pkg::evt_t       evt
);

  logic                 raw_pressed_r,    raw_pressed_nxt;
  logic [TIME_BITS-1:0] raw_change_r,     raw_change_nxt;
  logic                 stable_pressed_r, stable_pressed_nxt;
  logic [TIME_BITS-1:0] press_start_r,    press_start_nxt;
  logic                 long_fired_r,     long_fired_nxt;

  logic                 pressed;
  logic                 active;
  logic                 commit;
  logic                 long_hit;
  logic [TIME_BITS-1:0] raw_elapsed;
  logic [TIME_BITS-1:0] hold_elapsed;
  logic [TIME_BITS-1:0] boot_ext;
  logic [TIME_BITS-1:0] deb_ext;
  logic [TIME_BITS-1:0] long_ext;

  assign pressed  = ~pin_level;
  assign boot_ext = TIME_BITS'(cfg.boot_ignore_ms);
  assign deb_ext  = TIME_BITS'(cfg.debounce_ms);
  assign long_ext = TIME_BITS'(cfg.long_press_ms);
  assign active   = fire & cfg.enabled & (now >= boot_ext);

  // poll update: raw tracking, debounce commit, short and long events
  always_comb begin
    raw_pressed_nxt    = raw_pressed_r;
    raw_change_nxt     = raw_change_r;
    stable_pressed_nxt = stable_pressed_r;
    press_start_nxt    = press_start_r;
    long_fired_nxt     = long_fired_r;
    evt.valid          = 1'b0;
    evt.kind           = bdsl_pkg::KIND_SHORT;

    if (pressed != raw_pressed_r) begin
      raw_pressed_nxt = pressed;
      raw_change_nxt  = now;
    end
    raw_elapsed = now - raw_change_nxt;
    commit      = (pressed != stable_pressed_r) && (raw_elapsed >= deb_ext);

    if (commit) begin
      stable_pressed_nxt = pressed;
      if (pressed) begin
        press_start_nxt = now;
        long_fired_nxt  = 1'b0;
      end else if (!long_fired_r) begin
        evt.valid = 1'b1;
        evt.kind  = bdsl_pkg::KIND_SHORT;
      end
    end

    hold_elapsed = now - press_start_nxt;
    long_hit     = stable_pressed_nxt && !long_fired_nxt && (hold_elapsed >= long_ext);
    if (long_hit) begin
      long_fired_nxt = 1'b1;
      evt.valid      = 1'b1;
      evt.kind       = bdsl_pkg::KIND_LONG;
    end

    // ignored poll leaves everything as it was
    if (!active) begin
      raw_pressed_nxt    = raw_pressed_r;
      raw_change_nxt     = raw_change_r;
      stable_pressed_nxt = stable_pressed_r;
      press_start_nxt    = press_start_r;
      long_fired_nxt     = long_fired_r;
      evt.valid          = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_pressed_r    <= 1'b0;
      raw_change_r     <= '0;
      stable_pressed_r <= 1'b0;
      press_start_r    <= '0;
      long_fired_r     <= 1'b0;
    end else begin
      raw_pressed_r    <= raw_pressed_nxt;
      raw_change_r     <= raw_change_nxt;
      stable_pressed_r <= stable_pressed_nxt;
      press_start_r    <= press_start_nxt;
      long_fired_r     <= long_fired_nxt;
    end
  end

endmodule

@@ rtl/button_debounce_short_long_press_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_short_long_press_unit
// Debounced push button poll processor with short and long press events.
//
// Input channel: one beat per poll (in_now_ms timestamp, in_pin_level raw
// active-low level). Output channel: at most one beat per poll carrying
// out_press_kind (0 short press released, 1 long press while held).
// Configuration: cfg_we writes cfg_data to register cfg_index (0 enabled,
// 1 boot window, 2 debounce time, 3 long press time); the user must write
// only while idle; the block does not enforce it. A poll is captured in an
// input register and evaluated against the button state once the result
// register is free or draining. One poll per cycle is sustained while
// out_stall holds no result. A poll that gives no event frees its slot
// without an output beat. When out_stall holds a result, the input register
// keeps its poll and in_stall rises until the result is taken. Reset clears
// the button state, empties both registers and loads the registers with
// disabled, 100 ms boot window, 30 ms debounce, 1500 ms long.
// ----------------------------------------------------------------------------
module button_debounce_short_long_press_unit #(
  parameter int TIME_BITS = bdsl_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bdsl_pkg::NOW_BITS-1:0]     in_now_ms,
  input  logic                              in_pin_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_press_kind,
  input  logic                              cfg_we,
  input  logic [bdsl_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bdsl_pkg::CFG_BITS-1:0]     cfg_data
);

  localparam int NowW = bdsl_pkg::NOW_BITS;

  bdsl_pkg::cfg_t       cfg_r;
  logic                 in_valid_r;
  logic [NowW-1:0]      now_r;
  logic                 pin_r;
  logic                 out_valid_r;
  logic                 kind_r;
  logic                 advance;
  logic                 take_in;
  logic [TIME_BITS-1:0] now_t;
  bdsl_pkg::evt_t       evt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled        <= 1'b0;
      cfg_r.boot_ignore_ms <= bdsl_pkg::BOOT_IGNORE_RST;
      cfg_r.debounce_ms    <= bdsl_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ms  <= bdsl_pkg::LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (bdsl_pkg::reg_idx_t'(cfg_index))
        bdsl_pkg::REG_ENABLED:     cfg_r.enabled        <= cfg_data[0];
        bdsl_pkg::REG_BOOT_IGNORE: cfg_r.boot_ignore_ms <= cfg_data;
        bdsl_pkg::REG_DEBOUNCE:    cfg_r.debounce_ms    <= cfg_data;
        bdsl_pkg::REG_LONG_PRESS:  cfg_r.long_press_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: evaluate when the result register is free or draining
  assign advance  = ~out_valid_r | ~out_stall;
  assign in_stall = in_valid_r & ~advance;
  assign take_in  = in_valid & ~in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || advance) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      now_r <= in_now_ms;
      pin_r <= in_pin_level;
    end
  end

  // timestamp taken modulo the timer width
  generate
    if (TIME_BITS <= NowW) begin : g_trunc
      assign now_t = now_r[TIME_BITS-1:0];
    end else begin : g_ext
      assign now_t = {{(TIME_BITS - NowW){1'b0}}, now_r};
    end
  endgenerate

  bdsl_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_valid_r & advance),
    .now       (now_t),
    .pin_level (pin_r),
    .cfg       (cfg_r),
    .evt       (evt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && evt.valid) begin
      kind_r <= evt.kind;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_press_kind = kind_r;

endmodule
